@@ src/dkrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkrt_pkg: shared types for the dual key record table
// Field widths, request and status codes, record layout, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dkrt_pkg;

  localparam int unsigned ReqW   = 3;
  localparam int unsigned NumW   = 32;
  localparam int unsigned NameW  = 64;
  localparam int unsigned LenW   = 4;
  localparam int unsigned StatW  = 2;
  localparam int unsigned NameBytes = NameW / 8;

  // Number returned by a get by name that finds nothing.
  localparam logic signed [NumW-1:0] NoMatchNum = '1;

  typedef enum logic [ReqW-1:0] {
    REQ_ADD      = 3'd0,
    REQ_DEL_NUM  = 3'd1,
    REQ_DEL_NAME = 3'd2,
    REQ_GET_NUM  = 3'd3,
    REQ_GET_NAME = 3'd4
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_LONG = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // What goes into the found fields of a result.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_NUM    = 2'd2,
    KIND_NO_NUM = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic signed [NumW-1:0] num;
    logic [NameW-1:0]       name;
  } record_t;

  typedef struct packed {
    logic      load_req;
    logic      add_write;
    logic      rd_clear;
    logic      rd_issue;
    logic      sh_write;
    logic      cnt_dec;
    logic      res_set;
    status_e   res_status;
    res_kind_e res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic too_long;
    logic full;
    logic more;
    logic hit;
    logic rd_vld;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ src/dkrt_intf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkrt request and response channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dkrt_req_if
  import dkrt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [ReqW-1:0]        req_type;
  logic signed [NumW-1:0] phone_number;
  logic [NameW-1:0]       name_chars;
  logic [LenW-1:0]        name_length;

  modport source (output valid, output req_type, output phone_number,
                  output name_chars, output name_length, input ready);
  modport sink   (input valid, input req_type, input phone_number,
                  input name_chars, input name_length, output ready);
endinterface

interface dkrt_rsp_if
  import dkrt_pkg::*;
#(
  parameter int unsigned CNT_W = 5
) ();
  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic signed [NumW-1:0] found_number;
  logic [NameW-1:0]       found_name;
  logic [CNT_W-1:0]       entry_count;

  modport source (output valid, output status, output found_number,
                  output found_name, output entry_count, input ready);
  modport sink   (input valid, input status, input found_number,
                  input found_name, input entry_count, output ready);
endinterface
`default_nettype wire

@@ src/dkrt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkrt_datapath: record memory, request and result registers
// Holds the record memory with one write and one registered read port, the
// walk pointers, the entry count, key compare and the output register.
// ----------------------------------------------------------------------------
module dkrt_datapath
  import dkrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH    = 16,
  parameter int unsigned MAX_NAME_BYTES = 8,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [ReqW-1:0]        req_type_i,
  input  logic signed [NumW-1:0] phone_number_i,
  input  logic [NameW-1:0]       name_chars_i,
  input  logic [LenW-1:0]        name_length_i,
  input  logic                   rsp_ready_i,
  output logic                   rsp_valid_o,
  output status_e                status_o,
  output logic signed [NumW-1:0] found_number_o,
  output logic [NameW-1:0]       found_name_o,
  output logic [CntW-1:0]        entry_count_o
);

  record_t rec_mem [TABLE_DEPTH];

  req_e                   req_q;
  logic signed [NumW-1:0] num_q;
  logic [NameW-1:0]       key_q;
  logic                   long_q;

  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] rd_idx_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  record_t         rd_data_q;

  status_e                res_status_q;
  logic signed [NumW-1:0] res_num_q;
  logic [NameW-1:0]       res_name_q;

  logic                   out_valid_q;
  status_e                out_status_q;
  logic signed [NumW-1:0] out_num_q;
  logic [NameW-1:0]       out_name_q;
  logic [CntW-1:0]        out_cnt_q;

  logic             name_long;
  logic [NameW-1:0] name_key;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  record_t          wr_data;
  logic             by_num;

  assign name_long = name_length_i > LenW'(MAX_NAME_BYTES);

  // Keep the leading bytes up to the length limit, stop at the first zero.
  always_comb begin : key_build
    logic          alive;
    logic [LenW-1:0] lim;
    lim      = name_long ? LenW'(MAX_NAME_BYTES) : name_length_i;
    name_key = '0;
    alive    = 1'b1;
    for (int i = 0; i < NameBytes; i++) begin
      alive = alive && (LenW'(i) < lim) && (name_chars_i[8*i +: 8] != 8'h00);
      if (alive) begin
        name_key[8*i +: 8] = name_chars_i[8*i +: 8];
      end
    end
  end

  // Single write port: append at the count, or move an entry down by one.
  assign wr_en   = cmd_i.add_write || cmd_i.sh_write;
  assign wr_addr = cmd_i.add_write ? cnt_q[IdxW-1:0] : IdxW'(cmp_idx_q - 1'b1);
  assign wr_data = cmd_i.add_write ? record_t'{num: num_q, name: key_q} : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= rec_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.add_write) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
      if (cmd_i.rd_clear) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_issue) begin
        rd_idx_q <= CntW'(rd_idx_q + 1'b1);
      end
      rd_vld_q <= cmd_i.rd_issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_e'(req_type_i);
      num_q  <= phone_number_i;
      key_q  <= name_key;
      long_q <= name_long;
    end
    if (cmd_i.rd_issue) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      unique case (cmd_i.res_kind)
        KIND_NAME: begin
          res_num_q  <= '0;
          res_name_q <= rd_data_q.name;
        end
        KIND_NUM: begin
          res_num_q  <= rd_data_q.num;
          res_name_q <= '0;
        end
        KIND_NO_NUM: begin
          res_num_q  <= NoMatchNum;
          res_name_q <= '0;
        end
        default: begin
          res_num_q  <= '0;
          res_name_q <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_num_q    <= res_num_q;
      out_name_q   <= res_name_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign by_num = (req_q == REQ_DEL_NUM) || (req_q == REQ_GET_NUM);

  assign sts_o.req      = req_q;
  assign sts_o.too_long = long_q;
  assign sts_o.full     = cnt_q == CntW'(TABLE_DEPTH);
  assign sts_o.more     = rd_idx_q < cnt_q;
  assign sts_o.hit      = rd_vld_q && (by_num ? (rd_data_q.num == num_q)
                                              : (rd_data_q.name == key_q));
  assign sts_o.rd_vld   = rd_vld_q;
  assign sts_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_number_o = out_num_q;
  assign found_name_o   = out_name_q;
  assign entry_count_o  = out_cnt_q;

  a_add_bumps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_write |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
    else $error("count did not advance after append");

  a_shift_has_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sh_write |-> rd_vld_q && (cmp_idx_q != '0))
    else $error("entry move without read data or below entry zero");

  a_no_result_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("result register overwritten before taken");

  a_dec_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> cnt_q != '0)
    else $error("delete from an empty table");

endmodule
`default_nettype wire

@@ src/dkrt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkrt_ctrl: request sequencer
// Steps each request through dispatch, table walk, entry move and result.
// ----------------------------------------------------------------------------
module dkrt_ctrl
  import dkrt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  res_kind_e   miss_kind;
  logic        is_get;

  assign req_ready_o = state_q == S_IDLE;
  assign miss_kind   = (sts_i.req == REQ_GET_NAME) ? KIND_NO_NUM : KIND_NONE;
  assign is_get      = (sts_i.req == REQ_GET_NUM) || (sts_i.req == REQ_GET_NAME);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.res_set = 1'b1;
        state_d       = S_FINISH;
        unique case (sts_i.req)
          REQ_ADD: begin
            priority if (sts_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else if (sts_i.too_long) begin
              cmd_o.res_status = ST_LONG;
            end else begin
              cmd_o.add_write = 1'b1;
            end
          end
          REQ_DEL_NUM, REQ_GET_NUM: begin
            cmd_o.res_set  = 1'b0;
            cmd_o.rd_clear = 1'b1;
            state_d        = S_SCAN;
          end
          REQ_DEL_NAME, REQ_GET_NAME: begin
            if (sts_i.too_long) begin
              cmd_o.res_status = ST_MISS;
              cmd_o.res_kind   = miss_kind;
            end else begin
              cmd_o.res_set  = 1'b0;
              cmd_o.rd_clear = 1'b1;
              state_d        = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts_i.hit) begin
          cmd_o.res_set = 1'b1;
          if (is_get) begin
            cmd_o.res_kind = (sts_i.req == REQ_GET_NUM) ? KIND_NAME : KIND_NUM;
            state_d        = S_FINISH;
          end else begin
            cmd_o.rd_issue = sts_i.more;
            state_d        = S_SHIFT;
          end
        end else if (sts_i.more) begin
          cmd_o.rd_issue = 1'b1;
        end else begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_MISS;
          cmd_o.res_kind   = miss_kind;
          state_d          = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (sts_i.rd_vld) begin
          cmd_o.sh_write = 1'b1;
          cmd_o.rd_issue = sts_i.more;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_shift_on_delete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (sts_i.req == REQ_DEL_NUM || sts_i.req == REQ_DEL_NAME))
    else $error("entry move outside a delete");

  a_get_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_get && (state_q != S_IDLE) |-> !cmd_o.add_write && !cmd_o.sh_write && !cmd_o.cnt_dec)
    else $error("lookup changed the table");

  a_accept_leads_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == S_DISPATCH)
    else $error("accepted item not dispatched");

endmodule
`default_nettype wire

@@ src/dual_key_record_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_key_record_table: unsorted record table with linear search
// Records of a signed number and a short name, kept in insertion order.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives exactly one result. An add, an
// unknown request or a name lookup or delete whose length is over the limit
// goes from accept through dispatch and result back to accept. Lookups and
// deletes walk the stored entries through the single registered read port of
// the record memory, one entry per cycle; after the match of a delete every
// later entry is read and written one slot lower, one per cycle. The result
// sits in an output register, so a new request is taken as soon as the
// previous one has been parked there, even if the sink has not yet taken it.
// Records above the entry count are never read, so the memory needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module dual_key_record_table
  import dkrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH    = 16,
  parameter int unsigned MAX_NAME_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dkrt_req_if.sink   req_i,
  dkrt_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  cmd_t                   cmd;
  sts_t                   sts;
  status_e                status;
  logic signed [NumW-1:0] found_number;
  logic [NameW-1:0]       found_name;
  logic [CntW-1:0]        entry_count;
  logic                   rsp_valid;

  // Sequencer: accepts an item in idle, then drives the datapath step by step.
  dkrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memory, key compare, count and the output register.
  dkrt_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_i.req_type),
    .phone_number_i (req_i.phone_number),
    .name_chars_i   (req_i.name_chars),
    .name_length_i  (req_i.name_length),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_valid),
    .status_o       (status),
    .found_number_o (found_number),
    .found_name_o   (found_name),
    .entry_count_o  (entry_count)
  );

  // Drive the response channel straight from the output register.
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.status       = status;
  assign rsp_o.found_number = found_number;
  assign rsp_o.found_name   = found_name;
  assign rsp_o.entry_count  = entry_count;

endmodule
`default_nettype wire

@@ sim/dual_key_record_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_key_record_table_tb: self-checking bench for the dual key record table
// Drives add, delete and get requests through the request channel, mirrors
// every accepted item in a shadow table of its own and checks each response,
// field by field, against the outcome the shadow table gives, in order.
// ----------------------------------------------------------------------------
module dual_key_record_table_tb;
  import dkrt_pkg::*;

  localparam int unsigned TableDepth   = 16;
  localparam int unsigned MaxNameBytes = 8;
  localparam int unsigned CntW         = $clog2(TableDepth + 1);

  // Request codes the block takes and ignores.
  localparam logic [ReqW-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [ReqW-1:0] REQ_UNUSED_LAST  = 3'd7;

  localparam logic signed [NumW-1:0] NumMin = {1'b1, {(NumW - 1) {1'b0}}};
  localparam logic signed [NumW-1:0] NumMax = {1'b0, {(NumW - 1) {1'b1}}};
  localparam logic [LenW-1:0]        LenMax = '1;

  localparam int unsigned RandomItems   = 480;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned RunLimitNs    = 4_000_000;

  typedef struct packed {
    logic [ReqW-1:0]        req_type;
    logic signed [NumW-1:0] phone_number;
    logic [NameW-1:0]       name_chars;
    logic [LenW-1:0]        name_length;
  } request_t;

  typedef struct packed {
    status_e                status;
    logic signed [NumW-1:0] found_number;
    logic [NameW-1:0]       found_name;
    logic [CntW-1:0]        entry_count;
  } response_t;

  logic clk;
  logic rst_n;

  dkrt_req_if req_if ();
  dkrt_rsp_if #(.CNT_W(CntW)) rsp_if ();

  dual_key_record_table #(
    .TABLE_DEPTH   (TableDepth),
    .MAX_NAME_BYTES(MaxNameBytes)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the record store, updated as each item is accepted.
  logic signed [NumW-1:0] shadow_num  [TableDepth];
  logic [NameW-1:0]       shadow_name [TableDepth];
  int unsigned            shadow_count = 0;

  // Responses owed by the block, oldest first.
  response_t pending_responses[$];

  int unsigned error_count  = 0;
  int unsigned snd_idle_pct = 32;
  int unsigned rcv_idle_pct = 81;
  bit          hold_off_req = 1'b0;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // Bail out if the block wedges; no correct run comes near this.
  initial begin
    #(RunLimitNs);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow table
  // --------------------------------------------------------------------------
  function automatic int find_by_number(logic signed [NumW-1:0] num);
    for (int i = 0; i < int'(shadow_count); i++)
      if (shadow_num[i] == num) return i;
    return -1;
  endfunction

  function automatic int find_by_name(logic [NameW-1:0] key);
    for (int i = 0; i < int'(shadow_count); i++)
      if (shadow_name[i] == key) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and return the response it owes.
  function automatic response_t table_outcome(request_t rq);
    response_t        rs;
    logic [NameW-1:0] key;
    bit               too_long;
    bit               stop;
    int               idx;
    too_long = rq.name_length > MaxNameBytes;
    // Build the name key: low bytes up to the length, cut at the first zero.
    key  = '0;
    stop = 1'b0;
    for (int i = 0; i < int'(MaxNameBytes); i++) begin
      if (!stop && i < int'(rq.name_length)) begin
        if (rq.name_chars[8*i +: 8] == 8'h00) stop = 1'b1;
        else key[8*i +: 8] = rq.name_chars[8*i +: 8];
      end
    end
    rs.status       = ST_OK;
    rs.found_number = '0;
    rs.found_name   = '0;
    idx             = -1;
    case (rq.req_type)
      REQ_ADD: begin
        // Fullness wins over a long name.
        if (shadow_count >= TableDepth) begin
          rs.status = ST_FULL;
        end else if (too_long) begin
          rs.status = ST_LONG;
        end else begin
          shadow_num[shadow_count]  = rq.phone_number;
          shadow_name[shadow_count] = key;
          shadow_count++;
        end
      end
      REQ_DEL_NUM, REQ_DEL_NAME: begin
        if (rq.req_type == REQ_DEL_NUM) idx = find_by_number(rq.phone_number);
        else if (!too_long) idx = find_by_name(key);
        if (idx < 0) begin
          rs.status = ST_MISS;
        end else begin
          // Close the gap: every later record moves down one slot.
          for (int i = idx; i + 1 < int'(shadow_count); i++) begin
            shadow_num[i]  = shadow_num[i + 1];
            shadow_name[i] = shadow_name[i + 1];
          end
          shadow_count--;
        end
      end
      REQ_GET_NUM: begin
        idx = find_by_number(rq.phone_number);
        if (idx < 0) rs.status = ST_MISS;
        else rs.found_name = shadow_name[idx];
      end
      REQ_GET_NAME: begin
        if (!too_long) idx = find_by_name(key);
        if (idx < 0) begin
          rs.status       = ST_MISS;
          rs.found_number = NoMatchNum;
        end else begin
          rs.found_number = shadow_num[idx];
        end
      end
      default: ;
    endcase
    rs.entry_count = CntW'(shadow_count);
    return rs;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic request_t make_request(logic [ReqW-1:0] kind,
                                            logic signed [NumW-1:0] num,
                                            logic [NameW-1:0] chars,
                                            logic [LenW-1:0] len);
    request_t rq;
    rq.req_type     = kind;
    rq.phone_number = num;
    rq.name_chars   = chars;
    rq.name_length  = len;
    return rq;
  endfunction

  // Draw a request that mostly hits the records the shadow table holds, so
  // deletes shift and gets return data; the rest are misses and noise.
  function automatic request_t random_request();
    request_t         rq;
    logic [NameW-1:0] key;
    logic [NameW-1:0] junk;
    logic [NameW-1:0] ones;
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      kl;
    int unsigned      pos;
    bit               hit;
    ones = '1;
    junk = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      rq.req_type = ReqW'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
    end else if (pick < ((shadow_count > 12) ? 18 : 40)) begin
      rq.req_type = REQ_ADD;
    end else begin
      case ($urandom_range(0, 3))
        0:       rq.req_type = REQ_DEL_NUM;
        1:       rq.req_type = REQ_DEL_NAME;
        2:       rq.req_type = REQ_GET_NUM;
        default: rq.req_type = REQ_GET_NAME;
      endcase
    end
    // On an add a hit means a duplicate key.
    hit = (shadow_count != 0) &&
          ($urandom_range(0, 99) < ((rq.req_type == REQ_ADD) ? 15 : 80));
    idx = (shadow_count != 0) ? $urandom_range(0, shadow_count - 1) : 0;

    if (hit) begin
      rq.phone_number = shadow_num[idx];
    end else begin
      case ($urandom_range(0, 9))
        0:       rq.phone_number = NumMin;
        1:       rq.phone_number = NumMax;
        2:       rq.phone_number = NumW'($urandom_range(0, 3)) - 1;
        default: rq.phone_number = $urandom;
      endcase
    end

    if (hit) begin
      // Rebuild the stored name with junk above its end, either cut by the
      // length or by a zero byte within the length.
      key = shadow_name[idx];
      kl  = 0;
      for (int b = 0; b < int'(MaxNameBytes); b++)
        if (key[8*b +: 8] != 8'h00 && kl == b) kl++;
      if (kl < MaxNameBytes && $urandom_range(0, 1) == 1) begin
        rq.name_length = LenW'($urandom_range(kl + 1, MaxNameBytes));
        rq.name_chars  = key | (junk & (ones << (8 * (kl + 1))));
      end else begin
        rq.name_length = LenW'(kl);
        rq.name_chars  = key | (junk & (ones << (8 * kl)));
      end
    end else if ($urandom_range(0, 3) == 0) begin
      // Tiny alphabet, so fresh names collide with stored ones.
      rq.name_chars        = junk;
      rq.name_chars[7:0]   = 8'h61 + 8'($urandom_range(0, 2));
      rq.name_chars[15:8]  = 8'h61 + 8'($urandom_range(0, 2));
      rq.name_length       = LenW'($urandom_range(1, 2));
    end else begin
      rq.name_chars  = junk;
      rq.name_length = LenW'($urandom_range(0, MaxNameBytes));
      if (rq.name_length != 0 && $urandom_range(0, 6) == 0) begin
        pos = $urandom_range(0, rq.name_length - 1);
        rq.name_chars[8*pos +: 8] = 8'h00;
      end
    end

    if ($urandom_range(0, 99) < 5)
      rq.name_length = LenW'($urandom_range(MaxNameBytes + 1, LenMax));
    return rq;
  endfunction

  // Offer one item, hold it until accepted, log the owed response, then
  // sometimes idle the channel for a random stretch.
  task automatic send_request(request_t rq);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= rq.req_type;
    req_if.phone_number <= rq.phone_number;
    req_if.name_chars   <= rq.name_chars;
    req_if.name_length  <= rq.name_length;
    do @(posedge clk); while (!req_if.ready);
    pending_responses.push_back(table_outcome(rq));
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
  endtask

  // Drop valid and hold until every owed response has come back.
  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty table misses, extreme keys, name cut rules, long names, duplicates,
  // shifting on delete, and the ignored request codes.
  task automatic test_basic_requests();
    // Lookups and deletes on the empty table all miss.
    send_request(make_request(REQ_GET_NUM, NumMin, '0, '0));
    send_request(make_request(REQ_GET_NAME, '0, '1, 4'd8));
    send_request(make_request(REQ_DEL_NUM, NumMax, '0, '0));
    send_request(make_request(REQ_DEL_NAME, '0, '0, '0));
    // Fill with extreme numbers and names.
    send_request(make_request(REQ_ADD, NumMin, '1, 4'd8));
    send_request(make_request(REQ_ADD, NumMax, 64'hFFFF_FFFF_FFFF_6261, 4'd2));
    send_request(make_request(REQ_ADD, '0, 64'hDEAD_BEEF_CAFE_F00D, 4'd0));
    send_request(make_request(REQ_ADD, -1, 64'h0000_00CC_BB00_0041, 4'd5));
    // Long names are refused and store nothing.
    send_request(make_request(REQ_ADD, 32'h1234_5678, '1, LenMax));
    send_request(make_request(REQ_ADD, 32'h1234_5678, 64'h4847_4645_4443_4241, 4'd9));
    // Duplicate of the second record.
    send_request(make_request(REQ_ADD, NumMax, 64'h6261, 4'd2));
    send_request(make_request(REQ_GET_NUM, NumMin, '0, '0));
    send_request(make_request(REQ_GET_NAME, '0, 64'h6261, 4'd2));
    send_request(make_request(REQ_GET_NAME, '0, 64'h5555_5555, 4'd0));
    // A hit whose number is -1 must still report ok.
    send_request(make_request(REQ_GET_NAME, '0, 64'h41, 4'd1));
    send_request(make_request(REQ_GET_NAME, '0, '1, 4'd8));
    send_request(make_request(REQ_GET_NAME, '0, '1, 4'd12));
    send_request(make_request(REQ_DEL_NAME, '0, 64'h6261, 4'd9));
    // Remove the first of the duplicates, then find the second one.
    send_request(make_request(REQ_DEL_NUM, NumMax, '0, '0));
    send_request(make_request(REQ_GET_NAME, '0, 64'h6261, 4'd2));
    send_request(make_request(REQ_DEL_NUM, 32'd12345, '0, '0));
    for (int k = REQ_UNUSED_FIRST; k <= REQ_UNUSED_LAST; k++)
      send_request(make_request(ReqW'(k), NumMax, '1, LenMax));
    send_request(make_request(REQ_GET_NUM, '0, '0, '0));
  endtask

  // Fill the table, then check that a full table refuses adds ahead of the
  // length check, and walk the longest delete shift.
  task automatic test_full_table();
    request_t rq;
    while (shadow_count < TableDepth) begin
      rq             = random_request();
      rq.req_type    = REQ_ADD;
      rq.name_length = LenW'($urandom_range(0, MaxNameBytes));
      send_request(rq);
    end
    send_request(make_request(REQ_ADD, NumMax, '1, LenMax));
    send_request(make_request(REQ_ADD, NumMin, 64'h41, 4'd1));
    send_request(make_request(REQ_GET_NUM, shadow_num[TableDepth - 1], '0, '0));
    send_request(make_request(REQ_DEL_NUM, shadow_num[0], '0, '0));
    send_request(make_request(REQ_GET_NAME, '0, shadow_name[shadow_count - 1], 4'd8));
    send_request(make_request(REQ_ADD, NumMin, '1, 4'd8));
  endtask

  // Stall the response side for a long stretch while items keep coming, so
  // the output register and the working slot fill and ready drops.
  task automatic test_output_backpressure();
    int unsigned saved_pct;
    wait_for_responses();
    saved_pct    = snd_idle_pct;
    snd_idle_pct = 0;
    hold_off_req = 1'b1;
    repeat (12) send_request(random_request());
    wait_for_responses();
    snd_idle_pct = saved_pct;
  endtask

  // Random traffic under one idling profile; ignored codes do not count.
  task automatic test_random_traffic(int unsigned n_items, int unsigned snd_pct,
                                     int unsigned rcv_pct);
    request_t    rq;
    int unsigned sent;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    sent         = 0;
    while (sent < n_items) begin
      rq = random_request();
      send_request(rq);
      if (rq.req_type <= REQ_GET_NAME) sent++;
    end
    // Pause the sender until the block has answered everything.
    wait_for_responses();
  endtask

  // --------------------------------------------------------------------------
  // Response side: random ready, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Compare every accepted response with the oldest owed one.
  initial begin
    response_t want;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        if (pending_responses.size() == 0) begin
          $error("response with none owed: status %0d count %0d",
                 rsp_if.status, rsp_if.entry_count);
          error_count++;
        end else begin
          want = pending_responses.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            error_count++;
          end
          if (rsp_if.found_number !== want.found_number) begin
            $error("found_number: expected %0d, actual %0d",
                   want.found_number, rsp_if.found_number);
            error_count++;
          end
          if (rsp_if.found_name !== want.found_name) begin
            $error("found_name: expected %h, actual %h",
                   want.found_name, rsp_if.found_name);
            error_count++;
          end
          if (rsp_if.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, rsp_if.entry_count);
            error_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Park the request channel and hold reset.
    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= '0;
    req_if.phone_number <= '0;
    req_if.name_chars   <= '0;
    req_if.name_length  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_requests();
    test_full_table();
    test_output_backpressure();
    // Three idling profiles: slow receiver, slow sender, then full rate.
    test_random_traffic(RandomItems / 3, 32, 81);
    test_random_traffic(RandomItems / 3, 81, 32);
    test_random_traffic(RandomItems / 3, 0, 0);

    // Drain, then give stray responses time to show up.
    wait_for_responses();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
